// ===== hw/rtl/ellp_pkg.sv =====
// Shared types, constants and step-angle trig table for the ellipse point generator.
`timescale 1ns / 1ps

package ellp_pkg;

    localparam int MAX_POINTS_DEF = 64;
    localparam int FRAC_BITS_DEF  = 16;

    localparam int COORD_W = 32;
    localparam int RAD_W   = 31;
    localparam int PC_W    = 7;
    localparam int IDX_W   = 6;

    localparam int TRIG_DEPTH = 64;
    localparam int TRIG_IDX_W = $clog2(TRIG_DEPTH);

    localparam logic [63:0] PI_Q62  = 64'hC90FDAA22168C235;
    localparam logic [63:0] Q62_ONE = 64'h4000000000000000;

    localparam logic [63:0] TAYLOR_SIN_DEN [12] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
        64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
    };
    localparam logic [63:0] TAYLOR_COS_DEN [12] = '{
        64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132,
        64'd182, 64'd240, 64'd306, 64'd380, 64'd462, 64'd552
    };

    typedef struct packed {
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
        logic        [RAD_W-1:0]   major_radius;
        logic        [RAD_W-1:0]   minor_radius;
        logic        [PC_W-1:0]    point_count;
    } ellp_in_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x_coord;
        logic signed [COORD_W-1:0] y_coord;
        logic        [IDX_W-1:0]   point_index;
        logic                      last_point;
    } ellp_out_t;

    typedef struct packed {
        logic             start;
        logic [RAD_W-1:0] num;
        logic [RAD_W-1:0] den;
    } ellp_div_req_t;

    typedef struct packed {
        logic             done;
        logic [RAD_W-1:0] quot;
    } ellp_div_rsp_t;

    typedef logic [TRIG_DEPTH-1:0][63:0] ellp_trig_rom_t;

    function automatic logic [COORD_W-1:0] sat32(input logic signed [65:0] v);
        logic signed [65:0] hi;
        logic signed [65:0] lo;
        hi = 66'sh0_7FFF_FFFF;
        lo = -66'sh0_8000_0000;
        if (v > hi)
            return 32'h7FFF_FFFF;
        else if (v < lo)
            return 32'h8000_0000;
        else
            return v[31:0];
    endfunction

    // Elaboration-time helpers for the trig table.
    function automatic logic [63:0] umul62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        p = p + (128'd1 << 61);
        return p[125:62];
    endfunction

    function automatic logic [63:0] smul62(input logic [63:0] a, input logic [63:0] b);
        logic        neg;
        logic [63:0] ua;
        logic [63:0] ub;
        logic [63:0] m;
        neg = a[63] ^ b[63];
        ua  = a[63] ? (64'd0 - a) : a;
        ub  = b[63] ? (64'd0 - b) : b;
        m   = umul62(ua, ub);
        return neg ? (64'd0 - m) : m;
    endfunction

    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] q;
        rem = '0;
        q   = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem  = rem - {1'b0, den};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // {cos, sin} of 2*pi/n in Q2.30
    function automatic logic [63:0] ellp_step_trig(input int n);
        logic        [63:0] x;
        logic        [63:0] st;
        logic        [63:0] ss;
        logic        [63:0] ct;
        logic        [63:0] cs;
        logic        [63:0] c;
        logic        [63:0] s;
        logic        [63:0] c2;
        logic        [63:0] s2;
        logic signed [63:0] cr;
        logic signed [63:0] sr;
        x  = udiv64(PI_Q62, 64'(4 * n));
        st = x;
        ss = x;
        ct = Q62_ONE;
        cs = Q62_ONE;
        for (int k = 1; k <= 12; k++) begin
            st = umul62(umul62(st, x), x) / TAYLOR_SIN_DEN[k-1];
            ct = umul62(umul62(ct, x), x) / TAYLOR_COS_DEN[k-1];
            if ((k % 2) == 1) begin
                ss = ss - st;
                cs = cs - ct;
            end else begin
                ss = ss + st;
                cs = cs + ct;
            end
        end
        c = cs;
        s = ss;
        for (int k = 0; k < 3; k++) begin
            c2 = smul62(c, c) - smul62(s, s);
            s2 = smul62(s, c) << 1;
            c  = c2;
            s  = s2;
        end
        cr = $signed(c + 64'h8000_0000) >>> 32;
        sr = $signed(s + 64'h8000_0000) >>> 32;
        return {cr[31:0], sr[31:0]};
    endfunction

    function automatic ellp_trig_rom_t ellp_build_trig();
        ellp_trig_rom_t rom;
        for (int i = 0; i < TRIG_DEPTH; i++)
            rom[i] = ellp_step_trig(i + 1);
        return rom;
    endfunction

    localparam ellp_trig_rom_t TRIG_ROM = ellp_build_trig();

endpackage

// ===== hw/rtl/ellp_div.sv =====
// Restoring radix-2 divider: saturated (num << FRAC_BITS) / den, one quotient bit per cycle.
`timescale 1ns / 1ps

module ellp_div #(
    parameter int FRAC_BITS = ellp_pkg::FRAC_BITS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  ellp_pkg::ellp_div_req_t req,
    output ellp_pkg::ellp_div_rsp_t rsp
);
    import ellp_pkg::*;

    localparam int NUM_W = RAD_W + FRAC_BITS;
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             active_reg, active_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic [NUM_W-1:0] num_reg;
    logic [RAD_W-1:0] den_reg;
    logic [RAD_W-1:0] rem_reg;
    logic [RAD_W-1:0] quot_reg;
    logic             ovf_reg;

    logic [RAD_W:0]   shifted;
    logic [RAD_W:0]   diff;
    logic             ge;

    assign shifted = {rem_reg, num_reg[NUM_W-1]};
    assign ge      = shifted >= {1'b0, den_reg};
    assign diff    = shifted - {1'b0, den_reg};

    always_comb
    begin
        active_next = active_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        if (req.start)
        begin
            active_next = 1'b1;
            cnt_next    = CNT_W'(NUM_W);
        end
        else if (active_reg)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            done_reg   <= done_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            num_reg  <= {req.num, {FRAC_BITS{1'b0}}};
            den_reg  <= req.den;
            rem_reg  <= '0;
            quot_reg <= '0;
            ovf_reg  <= 1'b0;
        end
        else if (active_reg)
        begin
            num_reg  <= num_reg << 1;
            rem_reg  <= ge ? diff[RAD_W-1:0] : shifted[RAD_W-1:0];
            quot_reg <= {quot_reg[RAD_W-2:0], ge};
            ovf_reg  <= ovf_reg | quot_reg[RAD_W-1];
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = ovf_reg ? {RAD_W{1'b1}} : quot_reg;

endmodule

// ===== hw/rtl/ellipse_point_generator.sv =====
// Top level: ellipse point generator with a shared multiplier under a step sequencer.
`timescale 1ns / 1ps

// Usage:
//   Command channel: drive ellipse and pulse start; the transfer happens at a
//   clock edge with start high and busy low. busy stays high for the whole run.
//   A point count of zero is taken and produces nothing; counts above
//   MAX_POINTS are clamped; a zero radius is treated as one LSB.
//   Result channel: each point appears on point for one cycle with point_valid
//   high; last_point marks the final one. The receiver cannot stall.
//   Timing: the two radius ratios come from one iterative divider, one bit per
//   cycle, before the first point. Every following point takes six products
//   through the one 32x32 multiplier plus the emit step.
//   Reset: asynchronous, active low; returns to idle with no strobe pending.

module ellipse_point_generator #(
    parameter int MAX_POINTS = ellp_pkg::MAX_POINTS_DEF,
    parameter int FRAC_BITS  = ellp_pkg::FRAC_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  ellp_pkg::ellp_in_t  ellipse,
    output logic                busy,
    output logic                point_valid,
    output ellp_pkg::ellp_out_t point
);
    import ellp_pkg::*;

    localparam int CNT_W   = $clog2(MAX_POINTS + 1);
    localparam int PIDX_W  = $clog2(MAX_POINTS);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_DIV_AB = 4'b0010,
        ST_DIV_BA = 4'b0100,
        ST_RUN    = 4'b1000
    } state_t;

    typedef enum logic [6:0] {
        SP_EMIT = 7'b0000001,
        SP_TY   = 7'b0000010,
        SP_TX   = 7'b0000100,
        SP_PX   = 7'b0001000,
        SP_NX   = 7'b0010000,
        SP_PY   = 7'b0100000,
        SP_NY   = 7'b1000000
    } step_t;

    state_t            state_reg, state_next;
    step_t             step_reg, step_next;
    logic [PIDX_W-1:0] idx_reg, idx_next;
    logic              point_valid_reg, point_valid_next;

    ellp_out_t                 point_reg;
    logic [CNT_W-1:0]          n_reg;
    logic [RAD_W-1:0]          a_reg;
    logic [RAD_W-1:0]          b_reg;
    logic signed [COORD_W-1:0] cx_reg;
    logic signed [COORD_W-1:0] cy_reg;
    logic signed [COORD_W-1:0] rmo_reg;
    logic signed [COORD_W-1:0] rom_reg;
    logic signed [COORD_W-1:0] cos_reg;
    logic signed [COORD_W-1:0] sin_reg;
    logic signed [COORD_W-1:0] rel_x_reg;
    logic signed [COORD_W-1:0] rel_y_reg;
    logic signed [COORD_W-1:0] ty_reg;
    logic signed [COORD_W-1:0] tx_reg;
    logic signed [63:0]        acc_reg;
    logic signed [63:0]        prod_reg;

    ellp_div_req_t div_req;
    ellp_div_rsp_t div_rsp;

    logic                      accept;
    logic                      accept_nz;
    logic [CNT_W-1:0]          n_sat;
    logic [RAD_W-1:0]          a_eff;
    logic [RAD_W-1:0]          b_eff;
    logic [TRIG_IDX_W-1:0]     trig_idx;
    logic [63:0]               trig_word;
    logic                      is_last;

    logic signed [COORD_W-1:0] mul_a;
    logic signed [COORD_W-1:0] mul_b;
    logic signed [63:0]        scl_sum;
    logic signed [63:0]        scl_shr;
    logic [COORD_W-1:0]        scl_val;
    logic signed [65:0]        rot_sum;
    logic signed [65:0]        rot_shr;
    logic [COORD_W-1:0]        rot_val;
    logic signed [65:0]        out_x;
    logic signed [65:0]        out_y;

    assign busy        = (state_reg != ST_IDLE);
    assign accept      = start & ~busy;
    assign accept_nz   = accept & (ellipse.point_count != '0);
    assign point_valid = point_valid_reg;
    assign point       = point_reg;

    always_comb
    begin
        if (ellipse.point_count > PC_W'(MAX_POINTS))
            n_sat = CNT_W'(MAX_POINTS);
        else
            n_sat = CNT_W'(ellipse.point_count);
    end

    assign a_eff     = (ellipse.major_radius == '0) ? RAD_W'(1) : ellipse.major_radius;
    assign b_eff     = (ellipse.minor_radius == '0) ? RAD_W'(1) : ellipse.minor_radius;
    assign trig_idx  = TRIG_IDX_W'(n_sat - CNT_W'(1));
    assign trig_word = TRIG_ROM[trig_idx];
    assign is_last   = (CNT_W'(idx_reg) == (n_reg - CNT_W'(1)));

    always_comb
    begin
        div_req.start = accept_nz | ((state_reg == ST_DIV_AB) & div_rsp.done);
        if (state_reg == ST_IDLE)
        begin
            div_req.num = a_eff;
            div_req.den = b_eff;
        end
        else
        begin
            div_req.num = b_reg;
            div_req.den = a_reg;
        end
    end

    ellp_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // shared multiplier operand select
    always_comb
    begin
        unique case (step_reg)
            SP_EMIT: begin mul_a = rmo_reg;   mul_b = rel_y_reg; end
            SP_TY:   begin mul_a = rom_reg;   mul_b = rel_x_reg; end
            SP_TX:   begin mul_a = rel_x_reg; mul_b = cos_reg;   end
            SP_PX:   begin mul_a = ty_reg;    mul_b = sin_reg;   end
            SP_NX:   begin mul_a = tx_reg;    mul_b = sin_reg;   end
            SP_PY:   begin mul_a = rel_y_reg; mul_b = cos_reg;   end
            default: begin mul_a = '0;        mul_b = '0;        end
        endcase
    end

    assign scl_sum = prod_reg + (64'sd1 <<< (FRAC_BITS - 1));
    assign scl_shr = scl_sum >>> FRAC_BITS;
    assign scl_val = sat32({{2{scl_shr[63]}}, scl_shr});

    always_comb
    begin
        if (step_reg == SP_NX)
            rot_sum = {{2{acc_reg[63]}}, acc_reg} - {{2{prod_reg[63]}}, prod_reg};
        else
            rot_sum = {{2{acc_reg[63]}}, acc_reg} + {{2{prod_reg[63]}}, prod_reg};
    end

    assign rot_shr = (rot_sum + (66'sd1 <<< 29)) >>> 30;
    assign rot_val = sat32(rot_shr);

    assign out_x = {{34{cx_reg[31]}}, cx_reg} + {{34{rel_x_reg[31]}}, rel_x_reg};
    assign out_y = {{34{cy_reg[31]}}, cy_reg} + {{34{rel_y_reg[31]}}, rel_y_reg};

    always_comb
    begin
        state_next       = state_reg;
        step_next        = step_reg;
        idx_next         = idx_reg;
        point_valid_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept_nz)
                    state_next = ST_DIV_AB;
            end
            ST_DIV_AB:
            begin
                if (div_rsp.done)
                    state_next = ST_DIV_BA;
            end
            ST_DIV_BA:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_RUN;
                    step_next  = SP_EMIT;
                    idx_next   = '0;
                end
            end
            ST_RUN:
            begin
                unique case (step_reg)
                    SP_EMIT:
                    begin
                        point_valid_next = 1'b1;
                        if (is_last)
                            state_next = ST_IDLE;
                        else
                            step_next = SP_TY;
                    end
                    SP_TY: step_next = SP_TX;
                    SP_TX: step_next = SP_PX;
                    SP_PX: step_next = SP_NX;
                    SP_NX: step_next = SP_PY;
                    SP_PY: step_next = SP_NY;
                    SP_NY:
                    begin
                        step_next = SP_EMIT;
                        idx_next  = idx_reg + PIDX_W'(1);
                    end
                    default: step_next = SP_EMIT;
                endcase
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            step_reg        <= SP_EMIT;
            idx_reg         <= '0;
            point_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            step_reg        <= step_next;
            idx_reg         <= idx_next;
            point_valid_reg <= point_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;

        if (accept_nz)
        begin
            cx_reg    <= ellipse.center_x;
            cy_reg    <= ellipse.center_y;
            a_reg     <= a_eff;
            b_reg     <= b_eff;
            n_reg     <= n_sat;
            cos_reg   <= trig_word[63:32];
            sin_reg   <= trig_word[31:0];
            rel_x_reg <= {1'b0, a_eff};
            rel_y_reg <= '0;
        end

        if ((state_reg == ST_DIV_AB) && div_rsp.done)
            rmo_reg <= {1'b0, div_rsp.quot};
        if ((state_reg == ST_DIV_BA) && div_rsp.done)
            rom_reg <= {1'b0, div_rsp.quot};

        if (state_reg == ST_RUN)
        begin
            unique case (step_reg)
                SP_EMIT:
                begin
                    point_reg.x_coord     <= sat32(out_x);
                    point_reg.y_coord     <= sat32(out_y);
                    point_reg.point_index <= IDX_W'(idx_reg);
                    point_reg.last_point  <= is_last;
                end
                SP_TY: ty_reg    <= scl_val;
                SP_TX: tx_reg    <= scl_val;
                SP_PX: acc_reg   <= prod_reg;
                SP_NX: rel_x_reg <= rot_val;
                SP_PY: acc_reg   <= prod_reg;
                SP_NY: rel_y_reg <= rot_val;
                default: acc_reg <= acc_reg;
            endcase
        end
    end

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept_nz |=> busy)
        else $error("busy not raised after a transfer with points");

    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (point_valid && point.last_point) |=> !point_valid)
        else $error("strobe right after the last point");

    a_more_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (point_valid && !point.last_point) |-> busy)
        else $error("run ended before the last point");

    a_div_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == ST_DIV_AB || state_reg == ST_DIV_BA))
        else $error("divider finished outside a divide state");

endmodule

// ===== verif/tb_ellipse_point_generator.sv =====
// Testbench for ellipse_point_generator: directed table plus random ellipses, checked point by point.
`timescale 1ns / 1ps

module tb_ellipse_point_generator;

    import ellp_pkg::*;

    localparam int          MAX_PTS    = 64;
    localparam int          FRAC       = 16;
    localparam int          STALL_MAX  = 2000;
    localparam int          TAIL_WAIT  = 40;
    localparam int          RAND_ITEMS = 190;
    localparam logic [63:0] PI_FIX62   = 64'hC90FDAA22168C235;
    localparam logic [63:0] ONE_FIX62  = 64'h4000000000000000;

    typedef struct {
        ellp_in_t           item;
        bit                 typed;
        logic signed [31:0] exp_x;
        logic signed [31:0] exp_y;
    } stim_row_t;

    logic      clk;
    logic      rst_n;
    logic      start;
    ellp_in_t  ellipse;
    logic      busy;
    logic      point_valid;
    ellp_out_t point;

    ellp_out_t pending_points [$];
    stim_row_t directed [$];
    int        mismatch_count;
    int        stall_cycles;

    // predictor state
    logic signed [31:0] cos_by_n [1:MAX_PTS];
    logic signed [31:0] sin_by_n [1:MAX_PTS];
    logic signed [31:0] cur_x;
    logic signed [31:0] cur_y;
    logic signed [31:0] ratio_ab;
    logic signed [31:0] ratio_ba;
    logic signed [31:0] cos_step;
    logic signed [31:0] sin_step;
    logic signed [31:0] hold_cx;
    logic signed [31:0] hold_cy;
    logic        [6:0]  pts_left;
    logic        [5:0]  last_idx;

    ellipse_point_generator dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .ellipse     (ellipse),
        .busy        (busy),
        .point_valid (point_valid),
        .point       (point)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [63:0] mul_fix62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        prod = (prod + (128'd1 << 61)) >> 62;
        return prod[63:0];
    endfunction

    function automatic logic signed [63:0] smul_fix62(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic [63:0] mag;
        mag = mul_fix62(a[63] ? -a : a, b[63] ? -b : b);
        return (a[63] ^ b[63]) ? -$signed(mag) : $signed(mag);
    endfunction

    // cos/sin of 2*pi/n in Q2.30: series at pi/(4n), then three angle doublings
    function automatic void step_angle_trig(input int n, output logic signed [31:0] cos_q30,
                                            output logic signed [31:0] sin_q30);
        logic        [63:0] ang;
        logic        [63:0] s_term;
        logic        [63:0] c_term;
        logic        [63:0] s_sum;
        logic        [63:0] c_sum;
        logic signed [63:0] cv;
        logic signed [63:0] sv;
        logic signed [63:0] cn;
        logic signed [63:0] cr;
        logic signed [63:0] sr;
        ang    = PI_FIX62 / (64'd4 * 64'(n));
        s_term = ang;
        s_sum  = ang;
        c_term = ONE_FIX62;
        c_sum  = ONE_FIX62;
        for (int k = 1; k <= 12; k++)
        begin
            s_term = mul_fix62(mul_fix62(s_term, ang), ang) / 64'((2 * k) * (2 * k + 1));
            c_term = mul_fix62(mul_fix62(c_term, ang), ang) / 64'((2 * k - 1) * (2 * k));
            if (k % 2 == 1)
            begin
                s_sum = s_sum - s_term;
                c_sum = c_sum - c_term;
            end
            else
            begin
                s_sum = s_sum + s_term;
                c_sum = c_sum + c_term;
            end
        end
        cv = c_sum;
        sv = s_sum;
        for (int d = 0; d < 3; d++)
        begin
            cn = smul_fix62(cv, cv) - smul_fix62(sv, sv);
            sv = smul_fix62(sv, cv) * 64'sd2;
            cv = cn;
        end
        cr = (cv + 64'sh80000000) >>> 32;
        sr = (sv + 64'sh80000000) >>> 32;
        cos_q30 = cr[31:0];
        sin_q30 = sr[31:0];
    endfunction

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sh7FFFFFFF)
            return 32'sh7FFFFFFF;
        if (v < -64'sh80000000)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] axis_ratio(input logic [30:0] num,
                                                      input logic [30:0] den);
        logic [63:0] q;
        q = ({33'd0, num} << FRAC) / {33'd0, den};
        return (q > 64'h7FFFFFFF) ? 32'sh7FFFFFFF : q[31:0];
    endfunction

    function automatic logic signed [31:0] scale_fix(input logic signed [31:0] r,
                                                     input logic signed [31:0] v);
        longint p;
        p = longint'(r) * longint'(v) + (longint'(1) <<< (FRAC - 1));
        return clamp32(p >>> FRAC);
    endfunction

    task automatic trace_ellipse(input ellp_in_t e);
        int                 n;
        logic        [30:0] a;
        logic        [30:0] b;
        logic signed [31:0] tx;
        logic signed [31:0] ty;
        longint             nx;
        longint             ny;
        ellp_out_t          pt;
        n = e.point_count;
        if (n == 0)
            return;
        if (n > MAX_PTS)
            n = MAX_PTS;
        a        = (e.major_radius == '0) ? 31'd1 : e.major_radius;
        b        = (e.minor_radius == '0) ? 31'd1 : e.minor_radius;
        hold_cx  = e.center_x;
        hold_cy  = e.center_y;
        ratio_ab = axis_ratio(a, b);
        ratio_ba = axis_ratio(b, a);
        cos_step = cos_by_n[n];
        sin_step = sin_by_n[n];
        cur_x    = {1'b0, a};
        cur_y    = '0;
        pts_left = 7'(n);
        for (int k = 0; k < n; k++)
        begin
            last_idx       = 6'(k);
            pt.x_coord     = clamp32(longint'(hold_cx) + longint'(cur_x));
            pt.y_coord     = clamp32(longint'(hold_cy) + longint'(cur_y));
            pt.point_index = 6'(k);
            pt.last_point  = (k == n - 1);
            pending_points.push_back(pt);
            pts_left = pts_left - 7'd1;
            if (k + 1 < n)
            begin
                ty    = scale_fix(ratio_ab, cur_y);
                tx    = scale_fix(ratio_ba, cur_x);
                nx    = longint'(cur_x) * longint'(cos_step) - longint'(ty) * longint'(sin_step);
                ny    = longint'(tx) * longint'(sin_step) + longint'(cur_y) * longint'(cos_step);
                cur_x = clamp32((nx + (longint'(1) <<< 29)) >>> 30);
                cur_y = clamp32((ny + (longint'(1) <<< 29)) >>> 30);
            end
        end
    endtask

    function automatic stim_row_t mk_row(input logic [31:0] cx, input logic [31:0] cy,
                                         input logic [30:0] a, input logic [30:0] b,
                                         input logic [6:0] n, input bit typed,
                                         input logic [31:0] ex, input logic [31:0] ey);
        stim_row_t r;
        r.item.center_x     = cx;
        r.item.center_y     = cy;
        r.item.major_radius = a;
        r.item.minor_radius = b;
        r.item.point_count  = n;
        r.typed             = typed;
        r.exp_x             = ex;
        r.exp_y             = ey;
        return r;
    endfunction

    function automatic logic [30:0] random_radius();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return 31'($urandom_range(0, 1));
        if (sel <= 2)
            return 31'($urandom);
        return 31'($urandom_range(1, 32'h00FFFFFF));
    endfunction

    function automatic ellp_in_t random_ellipse();
        ellp_in_t e;
        int       sel;
        if ($urandom_range(0, 1) == 0)
        begin
            e.center_x = $urandom;
            e.center_y = $urandom;
        end
        else
        begin
            e.center_x = $urandom_range(0, 32'h00FFFFFF) - 32'h00800000;
            e.center_y = $urandom_range(0, 32'h00FFFFFF) - 32'h00800000;
        end
        e.major_radius = random_radius();
        e.minor_radius = ($urandom_range(0, 7) == 0) ? e.major_radius : random_radius();
        sel = $urandom_range(0, 19);
        if (sel == 0)
            e.point_count = '0;
        else if (sel == 1)
            e.point_count = 7'($urandom_range(65, 127));
        else if (sel <= 3)
            e.point_count = 7'($urandom_range(17, 64));
        else
            e.point_count = 7'($urandom_range(1, 16));
        return e;
    endfunction

    // drive one command and hold it until the generator takes it with busy low
    task automatic issue(input ellp_in_t e, input int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        ellipse <= e;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic drain_points();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_points.size() != 0);
    endtask

    function automatic int random_gap();
        return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || point_valid)
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (point_valid)
            begin
                if (pending_points.size() == 0)
                begin
                    $display("%0t: unexpected point expected none actual %h", $realtime, point);
                    mismatch_count <= mismatch_count + 1;
                end
                else
                begin
                    if (point !== pending_points[0])
                    begin
                        if (point.x_coord !== pending_points[0].x_coord)
                            $display("%0t: x_coord expected %h actual %h", $realtime,
                                     pending_points[0].x_coord, point.x_coord);
                        if (point.y_coord !== pending_points[0].y_coord)
                            $display("%0t: y_coord expected %h actual %h", $realtime,
                                     pending_points[0].y_coord, point.y_coord);
                        if (point.point_index !== pending_points[0].point_index)
                            $display("%0t: point_index expected %0d actual %0d", $realtime,
                                     pending_points[0].point_index, point.point_index);
                        if (point.last_point !== pending_points[0].last_point)
                            $display("%0t: last_point expected %b actual %b", $realtime,
                                     pending_points[0].last_point, point.last_point);
                        mismatch_count <= mismatch_count + 1;
                    end
                    void'(pending_points.pop_front());
                end
            end
            if (stall_cycles >= STALL_MAX)
            begin
                $display("%0t: no transfer for %0d cycles", $realtime, stall_cycles);
                $display("ellipse_point_generator verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        start          = 1'b0;
        ellipse        = '0;
        mismatch_count = 0;
        stall_cycles   = 0;
        cur_x          = '0;
        cur_y          = '0;
        ratio_ab       = '0;
        ratio_ba       = '0;
        cos_step       = '0;
        sin_step       = '0;
        hold_cx        = '0;
        hold_cy        = '0;
        pts_left       = '0;
        last_idx       = '0;
        for (int n = 1; n <= MAX_PTS; n++)
            step_angle_trig(n, cos_by_n[n], sin_by_n[n]);

        // single points, saturation, zero radius, zero count
        directed.push_back(mk_row(32'h0, 32'h0, 31'h00010000, 31'h00010000, 7'd1, 1,
                                  32'h00010000, 32'h0));
        directed.push_back(mk_row(32'h0, 32'h0, 31'h0, 31'h0, 7'd1, 1, 32'h00000001, 32'h0));
        directed.push_back(mk_row(32'h7FFFFFFF, 32'h80000000, 31'h7FFFFFFF, 31'h7FFFFFFF,
                                  7'd1, 1, 32'h7FFFFFFF, 32'h80000000));
        directed.push_back(mk_row(32'h80000000, 32'h7FFFFFFF, 31'h1, 31'h1, 7'd1, 1,
                                  32'h80000001, 32'h7FFFFFFF));
        directed.push_back(mk_row(32'hFFFB0000, 32'h00020000, 31'h00030000, 31'h00050000,
                                  7'd1, 1, 32'hFFFE0000, 32'h00020000));
        directed.push_back(mk_row(32'hFFFFFFFF, 32'hFFFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF,
                                  7'd0, 1, 32'h0, 32'h0));
        directed.push_back(mk_row(32'h0, 32'h0, 31'h0, 31'h0, 7'd0, 1, 32'h0, 32'h0));
        // predicted rows: short runs, full run, clamped counts, extreme ratios
        directed.push_back(mk_row(32'h0, 32'h0, 31'h00010000, 31'h00010000, 7'd2, 0, 0, 0));
        directed.push_back(mk_row(32'h00100000, 32'hFFF00000, 31'h00010000, 31'h00010000,
                                  7'd3, 0, 0, 0));
        directed.push_back(mk_row(32'h0, 32'h0, 31'h00640000, 31'h00320000, 7'd4, 0, 0, 0));
        directed.push_back(mk_row(32'h0, 32'h0, 31'h00030000, 31'h00070000, 7'd6, 0, 0, 0));
        directed.push_back(mk_row(32'h01000000, 32'h02000000, 31'h00500000, 31'h00280000,
                                  7'd64, 0, 0, 0));
        directed.push_back(mk_row(32'h0, 32'h0, 31'h00012345, 31'h00006789, 7'd65, 0, 0, 0));
        directed.push_back(mk_row(32'hFFFF0000, 32'h00010000, 31'h00020000, 31'h00020000,
                                  7'd127, 0, 0, 0));
        directed.push_back(mk_row(32'h0, 32'h0, 31'h7FFFFFFF, 31'h1, 7'd8, 0, 0, 0));
        directed.push_back(mk_row(32'h0, 32'h0, 31'h1, 31'h7FFFFFFF, 7'd8, 0, 0, 0));
        directed.push_back(mk_row(32'h0, 32'h0, 31'h7FFFFFFF, 31'h7FFFFFFF, 7'd5, 0, 0, 0));
        directed.push_back(mk_row(32'h7FFFFFFF, 32'h7FFFFFFF, 31'h40000000, 31'h40000000,
                                  7'd12, 0, 0, 0));
        directed.push_back(mk_row(32'h80000000, 32'h80000000, 31'h40000000, 31'h20000000,
                                  7'd7, 0, 0, 0));
        directed.push_back(mk_row(32'h55555555, 32'hAAAAAAAA, 31'h2AAAAAAA, 31'h55555555,
                                  7'd10, 0, 0, 0));
        directed.push_back(mk_row(32'h0, 32'h0, 31'h0, 31'h00010000, 7'd9, 0, 0, 0));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            issue(directed[i].item, random_gap());
            if (!directed[i].typed)
                trace_ellipse(directed[i].item);
            else if (directed[i].item.point_count == 7'd1)
                pending_points.push_back({directed[i].exp_x, directed[i].exp_y, 6'd0, 1'b1});
        end
        drain_points();

        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            ellp_in_t e;
            e = random_ellipse();
            if (i == RAND_ITEMS / 2)
                drain_points();
            issue(e, (i < RAND_ITEMS - 30) ? random_gap() : 0);
            trace_ellipse(e);
        end

        drain_points();
        repeat (TAIL_WAIT) @(posedge clk);
        if (mismatch_count == 0 && pending_points.size() == 0)
            $display("ellipse_point_generator verification clean");
        else
            $display("ellipse_point_generator verification failed");
        $finish;
    end

endmodule

// ===== ellipse_point_generator.f =====
hw/rtl/ellp_pkg.sv
hw/rtl/ellp_div.sv
hw/rtl/ellipse_point_generator.sv
verif/tb_ellipse_point_generator.sv
